// File: sv/assert_macros.svh
// Assertion macros shared by the cache RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on each rising edge outside reset
`define LKVC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on each rising edge outside reset
`define LKVC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/lkvc_pkg.sv
// Types and constants of the LRU key-value cache
`default_nettype none

package lkvc_pkg;

	localparam int unsigned KEY_W    = 32;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned CAP_W    = 5;
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned PDATA_W  = 32;

	localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
	localparam logic              REG_CAPACITY = 1'b0;
	localparam logic              REQ_GET    = 1'b0;
	localparam logic              REQ_SET    = 1'b1;
	localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_UPDATE
	} state_t;

	typedef enum logic {
		PH_SEARCH,
		PH_UPDATE
	} phase_t;

	// Which cell claims the write in an update pass
	typedef enum logic [1:0] {
		MD_MATCH,
		MD_FREE,
		MD_OLDEST
	} mode_t;

	typedef struct packed {
		logic                     req_type;
		logic signed [KEY_W-1:0]  lookup_key;
		logic signed [DATA_W-1:0] write_value;
	} req_t;

	typedef struct packed {
		logic                     hit;
		logic signed [DATA_W-1:0] read_value;
	} rsp_t;

	// Token handed from cell to cell; flag is "found" when searching, "claim pending" when updating
	typedef struct packed {
		logic              vld;
		phase_t            phase;
		mode_t             mode;
		logic              flag;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] data;
	} tok_t;

endpackage

`default_nettype wire

// File: sv/lkvc_cell.sv
// One cache entry cell: compares, ages and writes as the token passes through
`default_nettype none

module lkvc_cell #(
	parameter int unsigned REC_W = 4,
	parameter int unsigned LIM_W = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lkvc_pkg::tok_t    tok_in,
	input  wire logic [LIM_W-1:0]  lim_in,
	input  wire logic [REC_W-1:0]  max_in,
	output lkvc_pkg::tok_t         tok_out,
	output logic [LIM_W-1:0]       lim_out,
	output logic [REC_W-1:0]       max_out
);

	logic                          valid_q;
	logic [lkvc_pkg::KEY_W-1:0]    key_q;
	logic [lkvc_pkg::DATA_W-1:0]   data_q;
	logic [REC_W-1:0]              rec_q;
	lkvc_pkg::tok_t                tok_q;
	logic [LIM_W-1:0]              lim_q;
	logic [REC_W-1:0]              max_q;

	logic                          match;
	logic                          claim;
	logic                          do_srch;
	logic                          do_upd;
	logic [LIM_W-1:0]              rec_ext;
	lkvc_pkg::tok_t                tok_nxt;
	logic [LIM_W-1:0]              lim_nxt;
	logic [REC_W-1:0]              max_nxt;

	assign rec_ext = LIM_W'(rec_q);
	assign match   = valid_q && (key_q == tok_in.key);
	assign do_srch = tok_in.vld && (tok_in.phase == lkvc_pkg::PH_SEARCH);
	assign do_upd  = tok_in.vld && (tok_in.phase == lkvc_pkg::PH_UPDATE);

	// Decide whether this cell takes the write
	always_comb begin
		unique case (tok_in.mode)
			lkvc_pkg::MD_MATCH:  claim = match;
			lkvc_pkg::MD_FREE:   claim = !valid_q && tok_in.flag;
			lkvc_pkg::MD_OLDEST: claim = valid_q && tok_in.flag && (rec_ext == lim_in);
			default:             claim = 1'b0;
		endcase
	end

	// Fold this entry into the passing token
	always_comb begin
		tok_nxt = tok_in;
		lim_nxt = lim_in;
		max_nxt = max_in;
		if (do_srch && match) begin
			tok_nxt.flag = 1'b1;
			tok_nxt.data = data_q;
			lim_nxt      = rec_ext;
		end
		if (do_srch && valid_q && (rec_q > max_in)) begin
			max_nxt = rec_q;
		end
		if (do_upd && claim) begin
			tok_nxt.flag = 1'b0;
		end
	end

	// Hand the token on to the neighbour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	always_ff @(posedge clk) begin
		lim_q <= lim_nxt;
		max_q <= max_nxt;
	end

	// Claim the entry or age it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rec_q   <= '0;
		end else if (do_upd) begin
			if (claim) begin
				valid_q <= 1'b1;
				rec_q   <= '0;
			end else if (valid_q && (rec_ext < lim_in)) begin
				rec_q <= rec_q + 1'b1;
			end
		end
	end

	// Write key and value of a claimed entry
	always_ff @(posedge clk) begin
		if (do_upd && claim) begin
			key_q  <= tok_in.key;
			data_q <= tok_in.data;
		end
	end

	assign tok_out = tok_q;
	assign lim_out = lim_q;
	assign max_out = max_q;

endmodule

`default_nettype wire

// File: sv/lkvc_ctrl.sv
// Request sequencer: launches search and update passes and returns results
`default_nettype none

module lkvc_ctrl #(
	parameter int unsigned MAX_ENTRIES = 16,
	parameter int unsigned REC_W       = 4,
	parameter int unsigned LIM_W       = 5
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire lkvc_pkg::req_t                req,
	input  wire logic [lkvc_pkg::CAP_W-1:0]    capacity,
	output logic                               busy,
	output logic                               result_valid,
	output lkvc_pkg::rsp_t                     result,
	output lkvc_pkg::tok_t                     head_tok,
	output logic [LIM_W-1:0]                   head_lim,
	output logic [REC_W-1:0]                   head_max,
	input  wire lkvc_pkg::tok_t                tail_tok,
	input  wire logic [LIM_W-1:0]              tail_lim,
	input  wire logic [REC_W-1:0]              tail_max
);

	localparam int unsigned CMP_W = (LIM_W > lkvc_pkg::CAP_W) ? LIM_W : lkvc_pkg::CAP_W;

	lkvc_pkg::state_t        state_q;
	lkvc_pkg::state_t        state_nxt;
	lkvc_pkg::req_t          req_q;
	logic [LIM_W-1:0]        used_q;
	lkvc_pkg::tok_t          head_q;
	logic [LIM_W-1:0]        head_lim_q;
	logic [REC_W-1:0]        head_max_q;
	logic                    result_valid_q;
	lkvc_pkg::rsp_t          result_q;

	logic                    accept;
	logic                    srch_done;
	logic                    upd_done;
	logic                    need_upd;
	logic                    used_inc;
	lkvc_pkg::mode_t         upd_mode;
	logic [LIM_W-1:0]        upd_lim;
	logic [lkvc_pkg::DATA_W-1:0] upd_data;
	logic [CMP_W-1:0]        cap_ext;
	logic [CMP_W-1:0]        cap_eff;
	logic                    has_room;

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			lkvc_pkg::ST_IDLE: begin
				if (start) state_nxt = lkvc_pkg::ST_SEARCH;
			end
			lkvc_pkg::ST_SEARCH: begin
				if (srch_done) state_nxt = need_upd ? lkvc_pkg::ST_UPDATE : lkvc_pkg::ST_IDLE;
			end
			lkvc_pkg::ST_UPDATE: begin
				if (upd_done) state_nxt = lkvc_pkg::ST_IDLE;
			end
			default: state_nxt = lkvc_pkg::ST_IDLE;
		endcase
	end

	// Outputs and the decision taken at the end of a search pass
	always_comb begin
		busy      = (state_q != lkvc_pkg::ST_IDLE);
		accept    = start && !busy;
		srch_done = (state_q == lkvc_pkg::ST_SEARCH) && tail_tok.vld;
		upd_done  = (state_q == lkvc_pkg::ST_UPDATE) && tail_tok.vld;
		cap_ext   = CMP_W'(capacity);
		cap_eff   = (cap_ext > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_ext;
		has_room  = CMP_W'(used_q) < cap_eff;
		need_upd  = 1'b0;
		used_inc  = 1'b0;
		upd_mode  = lkvc_pkg::MD_MATCH;
		upd_lim   = tail_lim;
		upd_data  = tail_tok.data;
		priority if (req_q.req_type == lkvc_pkg::REQ_GET) begin
			need_upd = tail_tok.flag;
		end else if (capacity == '0) begin
			need_upd = 1'b0;
		end else if (tail_tok.flag) begin
			need_upd = 1'b1;
			upd_data = req_q.write_value;
		end else if (has_room) begin
			need_upd = 1'b1;
			used_inc = 1'b1;
			upd_mode = lkvc_pkg::MD_FREE;
			upd_lim  = LIM_W'(MAX_ENTRIES);
			upd_data = req_q.write_value;
		end else begin
			need_upd = 1'b1;
			upd_mode = lkvc_pkg::MD_OLDEST;
			upd_lim  = LIM_W'(tail_max);
			upd_data = req_q.write_value;
		end
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkvc_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Hold the request while its passes run
	always_ff @(posedge clk) begin
		if (accept) req_q <= req;
	end

	// Count the entries in use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (srch_done && used_inc) begin
			used_q <= used_q + 1'b1;
		end
	end

	// Launch a search token on accept, and an update token after the search when one is needed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else if (accept) begin
			head_q.vld   <= 1'b1;
			head_q.phase <= lkvc_pkg::PH_SEARCH;
			head_q.mode  <= lkvc_pkg::MD_MATCH;
			head_q.flag  <= 1'b0;
			head_q.key   <= req.lookup_key;
			head_q.data  <= '0;
		end else if (srch_done && need_upd) begin
			head_q.vld   <= 1'b1;
			head_q.phase <= lkvc_pkg::PH_UPDATE;
			head_q.mode  <= upd_mode;
			head_q.flag  <= 1'b1;
			head_q.key   <= req_q.lookup_key;
			head_q.data  <= upd_data;
		end else begin
			head_q.vld   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_lim_q <= '0;
			head_max_q <= '0;
		end else if (srch_done) begin
			head_lim_q <= upd_lim;
			head_max_q <= '0;
		end
	end

	// Return the get result for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= srch_done && (req_q.req_type == lkvc_pkg::REQ_GET);
		end
	end

	always_ff @(posedge clk) begin
		if (srch_done) begin
			result_q.hit        <= tail_tok.flag;
			result_q.read_value <= tail_tok.flag ? tail_tok.data : lkvc_pkg::MISS_VALUE;
		end
	end

	assign head_tok     = head_q;
	assign head_lim     = head_lim_q;
	assign head_max     = head_max_q;
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// File: sv/lru_key_value_cache_unit.sv
// Top level of the LRU key-value cache: register port, sequencer and cell chain
//
//  Port group        Direction  Handshake              Payload
//  request           in         start & !busy          req (req_t)
//  result            out        result_valid strobe    result (rsp_t)
//  configuration     in/out     APB, pready always 1   capacity at byte 0
//
// A request enters the chain at cell 0 and a token walks one cell a cycle.
// A get miss or an ignored set returns to idle after the search pass;
// a get hit or a stored set runs the search pass then the update pass.
// The get result strobe is registered from the end of the search pass.
// Reset empties all entries at once and restores capacity to 16.
// The result strobe cannot be held off; busy alone holds off new requests.
`default_nettype none

module lru_key_value_cache_unit #(
	parameter int unsigned MAX_ENTRIES = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire lkvc_pkg::req_t                    req,
	output logic                                   result_valid,
	output lkvc_pkg::rsp_t                         result,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [lkvc_pkg::PADDR_W-1:0]      paddr,
	input  wire logic [lkvc_pkg::PDATA_W-1:0]      pwdata,
	output logic [lkvc_pkg::PDATA_W-1:0]           prdata,
	output logic                                   pready
);

	`include "assert_macros.svh"

	localparam int unsigned REC_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned LIM_W = $clog2(MAX_ENTRIES + 1);

	logic [lkvc_pkg::CAP_W-1:0] capacity_q;
	logic                       reg_sel;

	lkvc_pkg::tok_t             tok_chain [0:MAX_ENTRIES];
	logic [LIM_W-1:0]           lim_chain [0:MAX_ENTRIES];
	logic [REC_W-1:0]           max_chain [0:MAX_ENTRIES];

	// Register decode ignores the byte offset
	assign reg_sel = (paddr[2] == lkvc_pkg::REG_CAPACITY);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? lkvc_pkg::PDATA_W'(capacity_q) : '0;

	// Write the capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lkvc_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			capacity_q <= pwdata[lkvc_pkg::CAP_W-1:0];
		end
	end

	lkvc_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.REC_W       (REC_W),
		.LIM_W       (LIM_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.req          (req),
		.capacity     (capacity_q),
		.busy         (busy),
		.result_valid (result_valid),
		.result       (result),
		.head_tok     (tok_chain[0]),
		.head_lim     (lim_chain[0]),
		.head_max     (max_chain[0]),
		.tail_tok     (tok_chain[MAX_ENTRIES]),
		.tail_lim     (lim_chain[MAX_ENTRIES]),
		.tail_max     (max_chain[MAX_ENTRIES])
	);

	// Chain of entry cells
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		lkvc_cell #(
			.REC_W (REC_W),
			.LIM_W (LIM_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok_chain[i]),
			.lim_in  (lim_chain[i]),
			.max_in  (max_chain[i]),
			.tok_out (tok_chain[i+1]),
			.lim_out (lim_chain[i+1]),
			.max_out (max_chain[i+1])
		);
	end

	// Checks
	`LKVC_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted item did not raise busy")
	`LKVC_ASSERT_NXT(a_strobe_single, clk, arst_n, result_valid, !result_valid, "result strobe held")
	`LKVC_ASSERT_IMP(a_miss_value, clk, arst_n, result_valid && !result.hit, result.read_value == lkvc_pkg::MISS_VALUE, "miss without all-ones value")
	`LKVC_ASSERT_IMP(a_head_busy, clk, arst_n, tok_chain[0].vld, busy, "token launched while idle")

endmodule

`default_nettype wire
